// ===== src/tnb_pkg.sv =====
// Shared types, constants and helper functions for the tanh neuron block.
// No dependencies; every other file refers to this package by scoped names.

package tnb_pkg;

  localparam int NUM_INPUTS_DEF   = 16;
  localparam int FRAC_BITS        = 12;
  localparam int TANH_TABLE_DEPTH = 1024;
  localparam int TANH_AW          = $clog2(TANH_TABLE_DEPTH);

  // Step in 2x between table entries (entry k holds tanh(k * TANH_R / 2)), Q32.32.
  localparam logic [63:0] TANH_R = (64'd16 << 32) / TANH_TABLE_DEPTH;

  localparam logic [15:0] LR_RESET = 16'd655;

  typedef enum logic [2:0] {
    OP_FWD      = 3'd0,
    OP_BACKPROP = 3'd1,
    OP_APPLY    = 3'd2,
    OP_CLEAR    = 3'd3,
    OP_WRITE    = 3'd4
  } op_t;

  // One row of the entry memory: weight, stored input and update sum.
  typedef struct packed {
    logic signed [31:0] wsum;
    logic signed [15:0] x;
    logic signed [15:0] w;
  } entry_t;

  typedef struct packed {
    logic               start;
    logic signed [31:0] dividend;
    logic [15:0]        divisor;
  } div_req_t;

  typedef struct packed {
    logic               done;
    logic signed [31:0] quotient;
  } div_rsp_t;

  typedef logic [15:0] tanh_tab_t [TANH_TABLE_DEPTH];

  function automatic logic signed [15:0] sat16(input logic signed [39:0] v);
    if (v > 40'sd32767) return 16'sh7fff;
    if (v < -40'sd32768) return 16'sh8000;
    return v[15:0];
  endfunction

  function automatic logic signed [31:0] sat32(input logic signed [39:0] v);
    if (v > 40'sd2147483647) return 32'sh7fffffff;
    if (v < -40'sd2147483648) return 32'sh80000000;
    return v[31:0];
  endfunction

  // Restoring long division, used only while the table is built.
  function automatic logic [63:0] udiv64(input logic [63:0] num, input logic [63:0] den);
    logic [63:0] quo;
    logic [64:0] rem;
    int          i;
    quo = '0;
    rem = '0;
    for (i = 63; i >= 0; i--) begin
      rem = {rem[63:0], num[i]};
      if (rem >= {1'b0, den}) begin
        rem    = rem - {1'b0, den};
        quo[i] = 1'b1;
      end
    end
    return quo;
  endfunction

  // Evaluated at elaboration only: exp(-r) by series, then powers of it.
  function automatic tanh_tab_t build_tanh();
    tanh_tab_t          tab;
    logic [63:0]        one;
    logic [63:0]        r;
    logic [63:0]        term;
    logic [63:0]        e;
    logic [63:0]        num;
    logic [63:0]        den;
    logic [63:0]        qv;
    logic signed [63:0] q;
    int                 n;
    int                 k;
    one  = 64'd1 << 32;
    r    = TANH_R;
    term = one;
    q    = $signed(one);
    e    = one;
    for (n = 1; n <= 12; n++) begin
      term = udiv64((term * r) >> 32, 64'(n));
      if (n % 2 == 1) q = q - $signed(term);
      else q = q + $signed(term);
    end
    qv = q;
    for (k = 0; k < TANH_TABLE_DEPTH; k++) begin
      if (k > 0) e = (e * qv + (64'd1 << 31)) >> 32;
      num = one - e;
      den = one + e;
      tab[k] = 16'(udiv64((num << FRAC_BITS) + (den >> 1), den));
    end
    return tab;
  endfunction

endpackage

// ===== src/tnb_tanh_rom.sv =====
// Tanh magnitude table with a registered read port.
// Depends on tnb_pkg for the table depth and the elaboration-time builder.

module tnb_tanh_rom (
  input  logic                         clk,
  input  logic [tnb_pkg::TANH_AW-1:0]  addr,
  output logic [15:0]                  q
);

  localparam tnb_pkg::tanh_tab_t TAB = tnb_pkg::build_tanh();

  always_ff @(posedge clk) begin
    q <= TAB[addr];
  end

endmodule

// ===== src/tnb_div.sv =====
// Bit-serial signed-by-unsigned divider, one quotient bit per cycle,
// truncating toward zero. Depends on tnb_pkg for the request/response types.

module tnb_div (
  input  logic              clk,
  input  logic              rst_n,
  input  tnb_pkg::div_req_t req,
  output tnb_pkg::div_rsp_t rsp
);

  logic        busy_r;
  logic        done_r;
  logic [4:0]  cnt_r;
  logic        neg_r;
  logic [15:0] rem_r;
  logic [15:0] dvs_r;
  logic [31:0] quo_r;
  logic [16:0] trial;
  logic        ge;
  logic [16:0] rem_nxt;

  assign trial   = {rem_r, quo_r[31]};
  assign ge      = trial >= {1'b0, dvs_r};
  assign rem_nxt = ge ? trial - {1'b0, dvs_r} : trial;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (req.start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 5'd1;
        if (cnt_r == 5'd31) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      neg_r <= req.dividend[31];
      quo_r <= req.dividend[31] ? 32'(-req.dividend) : 32'(req.dividend);
      rem_r <= '0;
      dvs_r <= req.divisor;
    end else if (busy_r) begin
      rem_r <= rem_nxt[15:0];
      quo_r <= {quo_r[30:0], ge};
    end
  end

  assign rsp.done     = done_r;
  assign rsp.quotient = neg_r ? -$signed(quo_r) : $signed(quo_r);

endmodule

// ===== src/tanh_neuron_with_backprop_core.sv =====
// One tanh neuron in fixed point: forward sum, table activation, and gradient
// descent training. All per-input state (weight, last input value and update
// sum) lives in one entry memory with a registered read; bias, sums and the
// activation are registers. After reset the block clears the entry memory
// before it takes its first beat. A forward beat reads, multiplies and
// accumulates; the last one of a run then reads the table and outputs. A
// backprop beat forms the error term and bias update in its error, derivative,
// gradient, rate and bias states, then a read, multiply, scale and write-back
// pipeline handles one weight and emits one gradient a cycle, holding whenever
// the result side stalls. Apply adds the update sums, divided by the train
// count in the bit-serial divider, to the bias and weights. Clear zeroes the
// update sums; a weight write reads the entry and writes back the new weight.
// Depends on tnb_pkg, tnb_tanh_rom and tnb_div.

module tanh_neuron_with_backprop_core #(
  parameter int NUM_INPUTS = tnb_pkg::NUM_INPUTS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  // configuration: learning rate, unsigned Q0.16
  input  logic        cfg_wr_en,
  input  logic [15:0] cfg_wr_data,
  // tdata, low bit first: index[4:0], data[20:5], is_output[21], ideal[37:22],
  // upstream_grad[53:38], accumulate[54], train_count[70:55], zero pad[71]
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [71:0] in_tdata,
  input  logic [2:0]  in_tuser,   // op
  input  logic        in_tlast,   // last
  output logic        out_tvalid,
  input  logic        out_tready,
  // tdata, low bit first: result_value[15:0], result_index[19:16], zero pad
  output logic [23:0] out_tdata,
  output logic [0:0]  out_tuser,  // kind
  output logic        out_tlast   // result_last
);

  localparam int AW    = (NUM_INPUTS > 1) ? $clog2(NUM_INPUTS) : 1;
  localparam int CW    = $clog2(NUM_INPUTS + 1);
  localparam int F     = tnb_pkg::FRAC_BITS;
  localparam int DEPTH = tnb_pkg::TANH_TABLE_DEPTH;
  localparam int TAW   = tnb_pkg::TANH_AW;
  localparam int WDW   = 49 - F;

  typedef enum logic [21:0] {
    ST_INIT     = 22'h000001,
    ST_IDLE     = 22'h000002,
    ST_FWD_RD   = 22'h000004,
    ST_FWD_MUL  = 22'h000008,
    ST_FWD_ACC  = 22'h000010,
    ST_TANH_RD  = 22'h000020,
    ST_TANH_OUT = 22'h000040,
    ST_BP_ERR   = 22'h000080,
    ST_BP_DRV   = 22'h000100,
    ST_BP_GRAD  = 22'h000200,
    ST_BP_LR    = 22'h000400,
    ST_BP_BIAS  = 22'h000800,
    ST_WALK     = 22'h001000,
    ST_AP_BIAS  = 22'h002000,
    ST_AP_BWAIT = 22'h004000,
    ST_AP_RD    = 22'h008000,
    ST_AP_DIV   = 22'h010000,
    ST_AP_WAIT  = 22'h020000,
    ST_CLR_RD   = 22'h040000,
    ST_CLR_WR   = 22'h080000,
    ST_WR_RD    = 22'h100000,
    ST_WR_WR    = 22'h200000
  } state_t;

  state_t state_r, state_nxt;

  // captured beat fields
  logic [4:0]         idx_r;
  logic signed [15:0] data_r;
  logic               last_r;
  logic               is_out_r;
  logic signed [15:0] ideal_r;
  logic signed [15:0] up_r;
  logic               acc_r;
  logic [15:0]        cnt_r;

  // architectural registers
  logic [15:0]        lr_r;
  logic signed [15:0] bias_r;
  logic signed [31:0] bsum_r;
  logic signed [31:0] pre_r;
  logic signed [15:0] act_r;
  logic               run_open_r;
  logic [CW-1:0]      walk_r;

  // working registers
  logic signed [31:0]  prod_r;
  logic signed [15:0]  err_r;
  logic signed [31:0]  vv_r;
  logic signed [F+17:0] gp_r;
  logic signed [15:0]  g_r;
  logic signed [32:0]  lrg_r;
  logic                neg_r;
  tnb_pkg::entry_t     hold_r;

  // backprop walk pipeline
  logic                v1_r, v2_r, v3_r;
  logic [AW-1:0]       idx1_r, idx2_r, idx3_r;
  logic signed [31:0]  px_r, pw_r;
  tnb_pkg::entry_t     e2_r, e3_r;
  logic signed [WDW-1:0] wdp_r;
  logic signed [15:0]  grad_r;

  // result register
  logic               out_valid_r;
  logic               out_kind_r;
  logic signed [15:0] out_val_r;
  logic [3:0]         out_idx_r;
  logic               out_last_r;

  // entry memory
  tnb_pkg::entry_t mem [NUM_INPUTS];
  tnb_pkg::entry_t rd_q;
  logic            mem_we;
  logic [AW-1:0]   mem_wa;
  tnb_pkg::entry_t mem_wd;
  logic [AW-1:0]   mem_ra;
  logic            mem_ren;

  tnb_pkg::div_req_t div_req;
  tnb_pkg::div_rsp_t div_rsp;

  logic [TAW-1:0]      rom_addr;
  logic [15:0]         rom_q;

  logic                in_acc;
  logic                idx_ok;
  logic                last_walk;
  logic                issue_v;
  logic                out_free;
  logic                walk_adv;
  logic                load_tanh;
  logic                load_grad;
  logic signed [15:0]  xs;
  logic [16:0]         ax;
  logic [31:0]         tscaled;
  logic [31:0]         tidx;
  logic signed [15:0]  tval;
  logic signed [17:0]  diff;
  logic signed [32:0]  dfull;
  logic [F:0]          dval;
  logic signed [16:0]  delta;
  logic signed [32-F:0] wd;
  tnb_pkg::entry_t     s3_wr;
  logic signed [15:0]  ap_w;

  assign in_tready = (state_r == ST_IDLE);
  assign in_acc    = in_tvalid && in_tready;
  assign idx_ok    = 32'(idx_r) < NUM_INPUTS;
  assign last_walk = 32'(walk_r) == NUM_INPUTS - 1;
  assign issue_v   = 32'(walk_r) < NUM_INPUTS;
  assign out_free  = !out_valid_r || out_tready;
  assign walk_adv  = !v3_r || out_free;
  assign load_tanh = (state_r == ST_TANH_OUT) && out_free;
  assign load_grad = (state_r == ST_WALK) && v3_r && out_free;

  // Table address from the saturated sum magnitude.
  assign xs      = tnb_pkg::sat16(40'(pre_r));
  assign ax      = xs[15] ? 17'(-17'(xs)) : 17'(xs);
  assign tscaled = 32'(ax) * 32'(DEPTH);
  assign tidx    = tscaled >> (F + 3);
  assign rom_addr = (tidx >= 32'(DEPTH)) ? TAW'(DEPTH - 1) : TAW'(tidx);
  assign tval    = neg_r ? -$signed(rom_q) : $signed(rom_q);

  assign diff  = 18'(act_r) - 18'(ideal_r);
  assign dfull = (33'sd1 <<< F) - 33'(vv_r >>> F);
  assign dval  = dfull[32] ? '0 : dfull[F:0];
  assign delta = $signed(lrg_r[32:16]);
  assign wd    = $signed(wdp_r[WDW-1:16]);
  assign ap_w  = tnb_pkg::sat16(40'($signed(hold_r.w)) + 40'(div_rsp.quotient));

  always_comb begin
    s3_wr = e3_r;
    if (acc_r) s3_wr.wsum = tnb_pkg::sat32(40'($signed(e3_r.wsum)) - 40'(wd));
    else s3_wr.w = tnb_pkg::sat16(40'($signed(e3_r.w)) - 40'(wd));
  end

  // Memory port and divider requests.
  always_comb begin
    mem_we  = 1'b0;
    mem_wa  = AW'(walk_r);
    mem_wd  = '0;
    mem_ra  = AW'(walk_r);
    mem_ren = 1'b1;
    div_req = '0;
    div_req.divisor = (cnt_r == 16'd0) ? 16'd1 : cnt_r;
    unique case (state_r)
      ST_INIT: begin
        mem_we = 1'b1;
      end
      ST_FWD_RD, ST_WR_RD: begin
        mem_ra = AW'(idx_r);
      end
      ST_FWD_MUL: begin
        mem_we = idx_ok;
        mem_wa = AW'(idx_r);
        mem_wd = '{wsum: rd_q.wsum, x: data_r, w: rd_q.w};
      end
      ST_WR_WR: begin
        mem_we = 1'b1;
        mem_wa = AW'(idx_r);
        mem_wd = '{wsum: rd_q.wsum, x: rd_q.x, w: data_r};
      end
      ST_WALK: begin
        // the read register holds while the pipeline is stalled
        mem_ren = walk_adv;
        mem_we  = v3_r && walk_adv;
        mem_wa  = idx3_r;
        mem_wd  = s3_wr;
      end
      ST_AP_BIAS: begin
        div_req.start    = 1'b1;
        div_req.dividend = bsum_r;
      end
      ST_AP_DIV: begin
        div_req.start    = 1'b1;
        div_req.dividend = rd_q.wsum;
      end
      ST_AP_WAIT: begin
        mem_we = div_rsp.done;
        mem_wd = '{wsum: '0, x: hold_r.x, w: ap_w};
      end
      ST_CLR_WR: begin
        mem_we = 1'b1;
        mem_wd = '{wsum: '0, x: rd_q.x, w: rd_q.w};
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) mem[mem_wa] <= mem_wd;
    if (mem_ren) rd_q <= mem[mem_ra];
  end

  // Next state.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_INIT:     if (last_walk) state_nxt = ST_IDLE;
      ST_IDLE: begin
        if (in_acc) begin
          case (in_tuser)
            tnb_pkg::OP_FWD:      state_nxt = ST_FWD_RD;
            tnb_pkg::OP_BACKPROP: state_nxt = ST_BP_ERR;
            tnb_pkg::OP_APPLY:    state_nxt = ST_AP_BIAS;
            tnb_pkg::OP_CLEAR:    state_nxt = ST_CLR_RD;
            tnb_pkg::OP_WRITE: begin
              if (32'(in_tdata[4:0]) < NUM_INPUTS) state_nxt = ST_WR_RD;
            end
            default:              state_nxt = ST_IDLE;
          endcase
        end
      end
      ST_FWD_RD:   state_nxt = ST_FWD_MUL;
      ST_FWD_MUL:  state_nxt = ST_FWD_ACC;
      ST_FWD_ACC:  state_nxt = last_r ? ST_TANH_RD : ST_IDLE;
      ST_TANH_RD:  state_nxt = ST_TANH_OUT;
      ST_TANH_OUT: if (out_free) state_nxt = ST_IDLE;
      ST_BP_ERR:   state_nxt = ST_BP_DRV;
      ST_BP_DRV:   state_nxt = ST_BP_GRAD;
      ST_BP_GRAD:  state_nxt = ST_BP_LR;
      ST_BP_LR:    state_nxt = ST_BP_BIAS;
      ST_BP_BIAS:  state_nxt = ST_WALK;
      ST_WALK: begin
        if (walk_adv && !issue_v && !v1_r && !v2_r) state_nxt = ST_IDLE;
      end
      ST_AP_BIAS:  state_nxt = ST_AP_BWAIT;
      ST_AP_BWAIT: if (div_rsp.done) state_nxt = ST_AP_RD;
      ST_AP_RD:    state_nxt = ST_AP_DIV;
      ST_AP_DIV:   state_nxt = ST_AP_WAIT;
      ST_AP_WAIT: begin
        if (div_rsp.done) state_nxt = last_walk ? ST_IDLE : ST_AP_RD;
      end
      ST_CLR_RD:   state_nxt = ST_CLR_WR;
      ST_CLR_WR:   state_nxt = last_walk ? ST_IDLE : ST_CLR_RD;
      ST_WR_RD:    state_nxt = ST_WR_WR;
      ST_WR_WR:    state_nxt = ST_IDLE;
      default:     state_nxt = ST_IDLE;
    endcase
  end

  // Control and architectural state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= ST_INIT;
      lr_r       <= tnb_pkg::LR_RESET;
      bias_r     <= '0;
      bsum_r     <= '0;
      pre_r      <= '0;
      act_r      <= '0;
      run_open_r <= 1'b0;
      walk_r     <= '0;
      v1_r       <= 1'b0;
      v2_r       <= 1'b0;
      v3_r       <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (cfg_wr_en) lr_r <= cfg_wr_data;
      unique case (state_r)
        ST_INIT: walk_r <= walk_r + CW'(1);
        ST_IDLE: begin
          walk_r <= '0;
          if (in_acc && in_tuser == tnb_pkg::OP_WRITE &&
              32'(in_tdata[4:0]) == NUM_INPUTS) begin
            bias_r <= $signed(in_tdata[20:5]);
          end
          if (in_acc && in_tuser == tnb_pkg::OP_CLEAR) bsum_r <= '0;
        end
        ST_FWD_ACC: begin
          if (idx_ok) begin
            pre_r <= tnb_pkg::sat32(40'(run_open_r ? pre_r : 32'(bias_r)) +
                                    40'(prod_r >>> F));
          end else if (!run_open_r) begin
            pre_r <= 32'(bias_r);
          end
          run_open_r <= !last_r;
        end
        ST_TANH_OUT: if (out_free) act_r <= tval;
        ST_BP_BIAS: begin
          if (acc_r) bsum_r <= tnb_pkg::sat32(40'(bsum_r) - 40'(delta));
          else bias_r <= tnb_pkg::sat16(40'(bias_r) - 40'(delta));
        end
        ST_WALK: begin
          if (walk_adv) begin
            v1_r <= issue_v;
            v2_r <= v1_r;
            v3_r <= v2_r;
            if (issue_v) walk_r <= walk_r + CW'(1);
          end
        end
        ST_AP_BWAIT: begin
          if (div_rsp.done) begin
            bias_r <= tnb_pkg::sat16(40'(bias_r) + 40'(div_rsp.quotient));
            bsum_r <= '0;
          end
        end
        ST_AP_WAIT: if (div_rsp.done) walk_r <= walk_r + CW'(1);
        ST_CLR_WR:  walk_r <= walk_r + CW'(1);
        default: begin
        end
      endcase
    end
  end

  // Datapath registers without reset.
  always_ff @(posedge clk) begin
    if (in_acc) begin
      idx_r    <= in_tdata[4:0];
      data_r   <= $signed(in_tdata[20:5]);
      last_r   <= in_tlast;
      is_out_r <= in_tdata[21];
      ideal_r  <= $signed(in_tdata[37:22]);
      up_r     <= $signed(in_tdata[53:38]);
      acc_r    <= in_tdata[54];
      cnt_r    <= in_tdata[70:55];
    end
    if (state_r == ST_FWD_MUL) prod_r <= $signed(rd_q.w) * data_r;
    if (state_r == ST_TANH_RD) neg_r <= xs[15];
    if (state_r == ST_BP_ERR) begin
      err_r <= is_out_r ? tnb_pkg::sat16(40'(diff) <<< 1) : up_r;
      vv_r  <= act_r * act_r;
    end
    if (state_r == ST_BP_DRV) gp_r <= err_r * $signed({1'b0, dval});
    if (state_r == ST_BP_GRAD) g_r <= tnb_pkg::sat16(40'(gp_r >>> F));
    if (state_r == ST_BP_LR) lrg_r <= $signed({1'b0, lr_r}) * g_r;
    if (state_r == ST_AP_DIV) hold_r <= rd_q;
    if (state_r == ST_WALK && walk_adv) begin
      idx1_r <= AW'(walk_r);
      px_r   <= g_r * $signed(rd_q.x);
      pw_r   <= g_r * $signed(rd_q.w);
      e2_r   <= rd_q;
      idx2_r <= idx1_r;
      wdp_r  <= $signed({1'b0, lr_r}) * $signed(px_r[31:F]);
      grad_r <= tnb_pkg::sat16(40'(pw_r >>> F));
      e3_r   <= e2_r;
      idx3_r <= idx2_r;
    end
  end

  // Result register: takes a new beat as soon as the previous one is gone.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (load_tanh || load_grad) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_tanh) begin
      out_kind_r <= 1'b0;
      out_val_r  <= tval;
      out_idx_r  <= '0;
      out_last_r <= 1'b1;
    end else if (load_grad) begin
      out_kind_r <= 1'b1;
      out_val_r  <= grad_r;
      out_idx_r  <= 4'(idx3_r);
      out_last_r <= 32'(idx3_r) == NUM_INPUTS - 1;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {4'b0, out_idx_r, out_val_r};
  assign out_tuser  = out_kind_r;
  assign out_tlast  = out_last_r;

  tnb_tanh_rom u_rom (
    .clk  (clk),
    .addr (rom_addr),
    .q    (rom_q)
  );

  tnb_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .rsp   (div_rsp)
  );

endmodule
